FILE: rtl/core/nbd_pkg.sv
// Shared types and constants of the block device protocol engine.
package nbd_pkg;

    localparam logic [1:0] FUNC_OPEN = 2'd0;
    localparam logic [1:0] FUNC_RX   = 2'd1;
    localparam logic [1:0] FUNC_TX   = 2'd2;

    localparam logic [2:0] PH_CLOSED  = 3'd0;
    localparam logic [2:0] PH_FLAGS   = 3'd1;
    localparam logic [2:0] PH_OPTHDR  = 3'd2;
    localparam logic [2:0] PH_OPTSKIP = 3'd3;
    localparam logic [2:0] PH_TRANS   = 3'd4;
    localparam logic [2:0] PH_WDATA   = 3'd5;

    localparam logic [2:0] RK_NONE   = 3'd0;
    localparam logic [2:0] RK_GREET  = 3'd1;
    localparam logic [2:0] RK_OPTION = 3'd2;
    localparam logic [2:0] RK_READ   = 3'd3;
    localparam logic [2:0] RK_WRITE  = 3'd4;

    localparam logic [15:0] CMD_READ       = 16'd0;
    localparam logic [15:0] CMD_WRITE      = 16'd1;
    localparam logic [15:0] CMD_DISCONNECT = 16'd2;

    localparam logic [7:0] GREET_LEN     = 8'd18;
    localparam logic [7:0] OPT_REPLY_LEN = 8'd134;
    localparam logic [7:0] HDR_LEN       = 8'd16;

    localparam logic [4:0] FLAGS_LAST  = 5'd3;
    localparam logic [4:0] OPTHDR_LAST = 5'd15;
    localparam logic [4:0] OPT_SIZE_AT = 5'd12;
    localparam logic [4:0] TYPE_AT     = 5'd6;
    localparam logic [4:0] HANDLE_AT   = 5'd8;
    localparam logic [4:0] OFFSET_AT   = 5'd16;
    localparam logic [4:0] LENGTH_AT   = 5'd24;
    localparam logic [4:0] REQ_LAST    = 5'd27;

    localparam logic [31:0] REPLY_MAGIC = 32'h67446698;

    localparam logic [7:0] GREET_TAB [16] = '{
        8'h4e, 8'h42, 8'h44, 8'h4d, 8'h41, 8'h47, 8'h49, 8'h43,
        8'h49, 8'h48, 8'h41, 8'h56, 8'h45, 8'h4f, 8'h50, 8'h54
    };

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       rx_accepted;
        logic       close_conn;
        logic       sel_disk;
    } res_t;

endpackage

FILE: rtl/core/nbd_disk.sv
// Disk store memory with post-reset clearing sweep and registered read.
module nbd_disk #(
    parameter int DISK_ADDR_BITS = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      we,
    input  logic                      re,
    input  logic [DISK_ADDR_BITS-1:0] addr,
    input  logic [7:0]                wdata,
    output logic [7:0]                rdata,
    output logic                      busy
);
    logic [7:0]              mem [2**DISK_ADDR_BITS];
    logic [DISK_ADDR_BITS:0] clr_reg;
    logic [7:0]              rdata_reg;

    assign busy  = !clr_reg[DISK_ADDR_BITS];
    assign rdata = rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (busy)
        begin
            clr_reg <= clr_reg + {{DISK_ADDR_BITS{1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            mem[clr_reg[DISK_ADDR_BITS-1:0]] <= 8'd0;
        end
        else if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end
endmodule

FILE: rtl/core/nbd_ctrl.sv
// Protocol sequencer: request parsing, reply generation and disk access control.
module nbd_ctrl #(
    parameter int DISK_ADDR_BITS = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [1:0]                func,
    input  logic [7:0]                rx_byte,
    input  logic [20:0]               disk_size,
    output logic                      mem_we,
    output logic                      mem_re,
    output logic [DISK_ADDR_BITS-1:0] mem_addr,
    output logic [7:0]                mem_wdata,
    output nbd_pkg::res_t             res
);
    import nbd_pkg::*;

    localparam logic [DISK_ADDR_BITS-1:0] PTR_ONE = {{(DISK_ADDR_BITS-1){1'b0}}, 1'b1};

    logic [2:0]                phase_reg,  phase_next;
    logic [4:0]                hcnt_reg,   hcnt_next;
    logic [15:0]               rtype_reg,  rtype_next;
    logic [63:0]               handle_reg, handle_next;
    logic [DISK_ADDR_BITS-1:0] ptr_reg,    ptr_next;
    logic [31:0]               len_reg,    len_next;
    logic [31:0]               cnt_reg,    cnt_next;
    logic [2:0]                kind_reg,   kind_next;
    logic [32:0]               idx_reg,    idx_next;

    logic [31:0] shifted_cnt;
    logic [31:0] shifted_len;
    logic [32:0] total;
    logic [32:0] idx_inc;
    logic [3:0]  lo;
    logic        idx_hdr;
    logic [63:0] ds64;
    logic [7:0]  tx_b;

    always_comb
    begin
        shifted_cnt = {cnt_reg[23:0], rx_byte};
        shifted_len = {len_reg[23:0], rx_byte};
        idx_inc     = idx_reg + 33'd1;
        lo          = idx_reg[3:0];
        idx_hdr     = (idx_reg[32:4] == 29'd0);
        ds64        = {43'd0, disk_size};
        case (kind_reg)
            RK_GREET:  total = 33'(GREET_LEN);
            RK_OPTION: total = 33'(OPT_REPLY_LEN);
            RK_READ:   total = 33'(HDR_LEN) + {1'b0, len_reg};
            RK_WRITE:  total = 33'(HDR_LEN);
            default:   total = 33'd0;
        endcase
        tx_b = 8'd0;
        case (kind_reg)
            RK_GREET:
            begin
                if (idx_hdr)
                begin
                    tx_b = GREET_TAB[lo];
                end
            end
            RK_OPTION:
            begin
                if (idx_hdr && !lo[3])
                begin
                    tx_b = ds64[{~lo[2:0], 3'b000} +: 8];
                end
            end
            default:
            begin
                if (lo[3])
                begin
                    tx_b = handle_reg[{~lo[2:0], 3'b000} +: 8];
                end
                else if (!lo[2])
                begin
                    tx_b = REPLY_MAGIC[{~lo[1:0], 3'b000} +: 8];
                end
            end
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hcnt_next   = hcnt_reg;
        rtype_next  = rtype_reg;
        handle_next = handle_reg;
        ptr_next    = ptr_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        res         = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = ptr_reg;
        mem_wdata   = rx_byte;
        if (accept)
        begin
            case (func)
                FUNC_OPEN:
                begin
                    phase_next  = PH_FLAGS;
                    hcnt_next   = 5'd0;
                    rtype_next  = 16'd0;
                    handle_next = 64'd0;
                    ptr_next    = '0;
                    len_next    = 32'd0;
                    cnt_next    = 32'd0;
                    kind_next   = RK_GREET;
                    idx_next    = 33'd0;
                end
                FUNC_RX:
                begin
                    if (phase_reg != PH_CLOSED && kind_reg == RK_NONE)
                    begin
                        res.rx_accepted = 1'b1;
                        case (phase_reg)
                            PH_FLAGS:
                            begin
                                hcnt_next = hcnt_reg + 5'd1;
                                if (hcnt_reg == FLAGS_LAST)
                                begin
                                    hcnt_next  = 5'd0;
                                    cnt_next   = 32'd0;
                                    phase_next = PH_OPTHDR;
                                end
                            end
                            PH_OPTHDR:
                            begin
                                if (hcnt_reg >= OPT_SIZE_AT)
                                begin
                                    cnt_next = shifted_cnt;
                                end
                                hcnt_next = hcnt_reg + 5'd1;
                                if (hcnt_reg == OPTHDR_LAST)
                                begin
                                    hcnt_next = 5'd0;
                                    if (shifted_cnt == 32'd0)
                                    begin
                                        kind_next  = RK_OPTION;
                                        idx_next   = 33'd0;
                                        phase_next = PH_TRANS;
                                    end
                                    else
                                    begin
                                        phase_next = PH_OPTSKIP;
                                    end
                                end
                            end
                            PH_OPTSKIP:
                            begin
                                cnt_next = cnt_reg - 32'd1;
                                if (cnt_reg == 32'd1)
                                begin
                                    kind_next  = RK_OPTION;
                                    idx_next   = 33'd0;
                                    phase_next = PH_TRANS;
                                end
                            end
                            PH_TRANS:
                            begin
                                if (hcnt_reg >= TYPE_AT && hcnt_reg < HANDLE_AT)
                                begin
                                    rtype_next = {rtype_reg[7:0], rx_byte};
                                end
                                else if (hcnt_reg >= HANDLE_AT && hcnt_reg < OFFSET_AT)
                                begin
                                    handle_next = {handle_reg[55:0], rx_byte};
                                end
                                else if (hcnt_reg >= OFFSET_AT && hcnt_reg < LENGTH_AT)
                                begin
                                    ptr_next = {ptr_reg[DISK_ADDR_BITS-9:0], rx_byte};
                                end
                                else if (hcnt_reg >= LENGTH_AT)
                                begin
                                    len_next = shifted_len;
                                end
                                hcnt_next = hcnt_reg + 5'd1;
                                if (hcnt_reg == REQ_LAST)
                                begin
                                    hcnt_next = 5'd0;
                                    if (rtype_reg == CMD_READ)
                                    begin
                                        kind_next = RK_READ;
                                        idx_next  = 33'd0;
                                    end
                                    else if (rtype_reg == CMD_WRITE)
                                    begin
                                        if (shifted_len == 32'd0)
                                        begin
                                            kind_next = RK_WRITE;
                                            idx_next  = 33'd0;
                                        end
                                        else
                                        begin
                                            cnt_next   = shifted_len;
                                            idx_next   = 33'd0;
                                            phase_next = PH_WDATA;
                                        end
                                    end
                                    else if (rtype_reg == CMD_DISCONNECT)
                                    begin
                                        phase_next     = PH_CLOSED;
                                        rtype_next     = 16'd0;
                                        handle_next    = 64'd0;
                                        ptr_next       = '0;
                                        len_next       = 32'd0;
                                        cnt_next       = 32'd0;
                                        kind_next      = RK_NONE;
                                        idx_next       = 33'd0;
                                        res.close_conn = 1'b1;
                                    end
                                end
                            end
                            PH_WDATA:
                            begin
                                mem_we   = 1'b1;
                                ptr_next = ptr_reg + PTR_ONE;
                                cnt_next = cnt_reg - 32'd1;
                                if (cnt_reg == 32'd1)
                                begin
                                    kind_next  = RK_WRITE;
                                    idx_next   = 33'd0;
                                    phase_next = PH_TRANS;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
                FUNC_TX:
                begin
                    if (kind_reg != RK_NONE)
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = tx_b;
                        if (kind_reg == RK_READ && !idx_hdr)
                        begin
                            mem_re       = 1'b1;
                            res.sel_disk = 1'b1;
                            ptr_next     = ptr_reg + PTR_ONE;
                        end
                        idx_next = idx_inc;
                        if (idx_inc >= total)
                        begin
                            res.tx_last = 1'b1;
                            kind_next   = RK_NONE;
                            idx_next    = 33'd0;
                        end
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CLOSED;
            hcnt_reg   <= 5'd0;
            rtype_reg  <= 16'd0;
            handle_reg <= 64'd0;
            ptr_reg    <= '0;
            len_reg    <= 32'd0;
            cnt_reg    <= 32'd0;
            kind_reg   <= RK_NONE;
            idx_reg    <= 33'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hcnt_reg   <= hcnt_next;
            rtype_reg  <= rtype_next;
            handle_reg <= handle_next;
            ptr_reg    <= ptr_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            kind_reg   <= kind_next;
            idx_reg    <= idx_next;
        end
    end
endmodule

FILE: rtl/core/nbd_server_protocol_engine.sv
// Top level of the byte-serial block device protocol engine.
// A request's result is registered and appears in the cycle after it is accepted.
// Throughput: one request per cycle unless in_stall holds it; disk reads use the store's registered read port.
// Reset: protocol state closed, disk_size 1048576; the store is then swept to zero,
// one byte a cycle over all 2**DISK_ADDR_BITS addresses, during which in_stall stays high.
module nbd_server_protocol_engine #(
    parameter int DISK_ADDR_BITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic        rx_accepted,
    output logic        close_conn,
    input  logic        disk_size_valid,
    output logic        disk_size_ready,
    input  logic [20:0] disk_size
);
    import nbd_pkg::*;

    logic                      accept;
    logic                      advance;
    logic                      busy;
    logic                      mem_we;
    logic                      mem_re;
    logic [DISK_ADDR_BITS-1:0] mem_addr;
    logic [7:0]                mem_wdata;
    logic [7:0]                mem_rdata;
    res_t                      res;
    res_t                      res_reg;
    logic                      out_valid_reg;
    logic [20:0]               dsize_reg;

    assign advance         = !out_valid_reg || !out_stall;
    assign in_stall        = busy || !advance;
    assign accept          = in_valid && !in_stall;
    assign disk_size_ready = 1'b1;

    nbd_ctrl #(.DISK_ADDR_BITS(DISK_ADDR_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (func),
        .rx_byte   (rx_byte),
        .disk_size (dsize_reg),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .res       (res)
    );

    nbd_disk #(.DISK_ADDR_BITS(DISK_ADDR_BITS)) u_disk (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata),
        .busy  (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            dsize_reg     <= 21'd1048576;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= accept;
            end
            if (disk_size_valid && disk_size_ready)
            begin
                dsize_reg <= disk_size;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tx_valid    = res_reg.tx_valid;
    assign tx_byte     = res_reg.sel_disk ? mem_rdata : res_reg.tx_byte;
    assign tx_last     = res_reg.tx_last;
    assign rx_accepted = res_reg.rx_accepted;
    assign close_conn  = res_reg.close_conn;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !accept)
        else $error("request accepted during store clear");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request produced no result");

    a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tx_last) |-> tx_valid)
        else $error("tx_last without tx_valid");

    a_rx_tx_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(rx_accepted && tx_valid))
        else $error("result both sends and takes a byte");
endmodule

FILE: sim/testbench.sv
// Testbench for the block device protocol engine: directed table, then random sessions.
`timescale 1ns / 1ps

module testbench;
    import nbd_pkg::*;

    localparam int ABITS = 12;
    localparam int DISK_BYTES = 1 << ABITS;

    typedef struct packed {
        logic       tv;
        logic [7:0] tb;
        logic       tl;
        logic       acc;
        logic       cls;
    } step_res_t;

    typedef struct {
        logic [1:0] f;
        logic [7:0] b;
        bit         typed;
        step_res_t  res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        rx_accepted;
    logic        close_conn;
    logic        disk_size_valid;
    logic        disk_size_ready;
    logic [20:0] disk_size;

    nbd_server_protocol_engine #(.DISK_ADDR_BITS(ABITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .func(func), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .tx_valid(tx_valid), .tx_byte(tx_byte), .tx_last(tx_last),
        .rx_accepted(rx_accepted), .close_conn(close_conn),
        .disk_size_valid(disk_size_valid), .disk_size_ready(disk_size_ready),
        .disk_size(disk_size)
    );

    logic [20:0] m_size;
    logic [2:0]  m_phase;
    logic [4:0]  m_hcount;
    logic [15:0] m_type;
    logic [63:0] m_handle;
    logic [63:0] m_offset;
    logic [31:0] m_length;
    logic [31:0] m_remain;
    logic [2:0]  m_kind;
    logic [63:0] m_index;
    logic [7:0]  m_disk [DISK_BYTES];

    step_res_t expected_q[$];
    int        errors = 0;
    int        items = 0;
    int        results = 0;
    int        burst_left = 0;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [63:0] reply_len();
        case (m_kind)
            RK_GREET:  return 64'd18;
            RK_OPTION: return 64'd134;
            RK_READ:   return 64'd16 + m_length;
            RK_WRITE:  return 64'd16;
            default:   return 64'd0;
        endcase
    endfunction

    function automatic logic [7:0] reply_at(logic [63:0] i);
        logic [63:0] s;
        if (m_kind == RK_GREET)
            return (i < 16) ? GREET_TAB[i] : 8'd0;
        if (m_kind == RK_OPTION)
        begin
            s = {43'd0, m_size};
            return (i < 8) ? s[8 * (7 - i) +: 8] : 8'd0;
        end
        if (i < 4)
            return REPLY_MAGIC[8 * (3 - i) +: 8];
        if (i < 8)
            return 8'd0;
        if (i < 16)
            return m_handle[8 * (15 - i) +: 8];
        return m_disk[(m_offset + i - 16) % DISK_BYTES];
    endfunction

    function automatic void restart_link();
        m_phase = PH_CLOSED;
        m_hcount = 0;
        m_type = 0;
        m_handle = 0;
        m_offset = 0;
        m_length = 0;
        m_remain = 0;
        m_kind = RK_NONE;
        m_index = 0;
    endfunction

    function automatic void start_reply(logic [2:0] k);
        m_kind = k;
        m_index = 0;
    endfunction

    function automatic logic absorb_byte(logic [7:0] b);
        case (m_phase)
            PH_FLAGS:
            begin
                m_hcount++;
                if (m_hcount >= 4)
                begin
                    m_hcount = 0;
                    m_remain = 0;
                    m_phase = PH_OPTHDR;
                end
            end
            PH_OPTHDR:
            begin
                if (m_hcount >= 12)
                    m_remain = {m_remain[23:0], b};
                m_hcount++;
                if (m_hcount >= 16)
                begin
                    m_hcount = 0;
                    if (m_remain == 0)
                    begin
                        start_reply(RK_OPTION);
                        m_phase = PH_TRANS;
                    end
                    else
                        m_phase = PH_OPTSKIP;
                end
            end
            PH_OPTSKIP:
            begin
                m_remain--;
                if (m_remain == 0)
                begin
                    start_reply(RK_OPTION);
                    m_phase = PH_TRANS;
                end
            end
            PH_TRANS:
            begin
                if (m_hcount >= 6 && m_hcount < 8)
                    m_type = {m_type[7:0], b};
                else if (m_hcount >= 8 && m_hcount < 16)
                    m_handle = {m_handle[55:0], b};
                else if (m_hcount >= 16 && m_hcount < 24)
                    m_offset = {m_offset[55:0], b};
                else if (m_hcount >= 24)
                    m_length = {m_length[23:0], b};
                m_hcount++;
                if (m_hcount >= 28)
                begin
                    m_hcount = 0;
                    if (m_type == CMD_READ)
                        start_reply(RK_READ);
                    else if (m_type == CMD_WRITE)
                    begin
                        if (m_length == 0)
                            start_reply(RK_WRITE);
                        else
                        begin
                            m_remain = m_length;
                            m_index = 0;
                            m_phase = PH_WDATA;
                        end
                    end
                    else if (m_type == CMD_DISCONNECT)
                    begin
                        restart_link();
                        return 1'b1;
                    end
                end
            end
            PH_WDATA:
            begin
                m_disk[(m_offset + (m_length - m_remain)) % DISK_BYTES] = b;
                m_remain--;
                if (m_remain == 0)
                begin
                    start_reply(RK_WRITE);
                    m_phase = PH_TRANS;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic step_res_t engine_step(logic [1:0] f, logic [7:0] b);
        step_res_t r;
        r = '0;
        if (f == FUNC_OPEN)
        begin
            restart_link();
            m_phase = PH_FLAGS;
            start_reply(RK_GREET);
        end
        else if (f == FUNC_RX)
        begin
            if (m_phase != PH_CLOSED && m_kind == RK_NONE)
            begin
                r.acc = 1'b1;
                r.cls = absorb_byte(b);
            end
        end
        else if (f == FUNC_TX && m_kind != RK_NONE)
        begin
            r.tv = 1'b1;
            r.tb = reply_at(m_index);
            m_index++;
            if (m_index >= reply_len())
            begin
                r.tl = 1'b1;
                m_kind = RK_NONE;
                m_index = 0;
            end
        end
        return r;
    endfunction

    task automatic send(logic [1:0] f, logic [7:0] b, bit typed = 0, step_res_t res = '0);
        step_res_t p;
        in_valid <= 1'b1;
        func <= f;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = engine_step(f, b);
        expected_q.push_back(typed ? res : p);
        items++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
    endtask

    task automatic put(logic [1:0] f, logic [7:0] b);
        if ($urandom_range(0, 19) == 0)
            send($urandom_range(0, 60) == 0 ? FUNC_OPEN : 2'($urandom_range(1, 3)),
                 8'($urandom));
        send(f, b);
    endtask

    task automatic drain(int n);
        repeat (n) put(FUNC_TX, 8'd0);
    endtask

    task automatic put_be(logic [63:0] v, int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            put(FUNC_RX, v[8 * i +: 8]);
    endtask

    task automatic run_session();
        int          skip;
        int          len;
        int          pick;
        logic [15:0] cmd;
        logic [63:0] offs;
        put(FUNC_OPEN, 8'($urandom));
        drain(18);
        put_be({$urandom, $urandom}, 4);
        skip = $urandom_range(0, 3);
        put_be({$urandom, $urandom}, 8);
        put_be(64'($urandom), 4);
        put_be(64'(skip), 4);
        repeat (skip) put(FUNC_RX, 8'($urandom));
        drain(134);
        for (int r = 0; r < 2; r++)
        begin
            pick = $urandom_range(0, 9);
            len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
            cmd = (pick < 4) ? CMD_READ : (pick < 8) ? CMD_WRITE : 16'($urandom_range(3, 65535));
            offs = {$urandom, $urandom};
            if ($urandom_range(0, 1))
                offs = 64'($urandom_range(0, 40));
            put_be(64'($urandom), 4);
            put_be(64'($urandom), 2);
            put_be(64'(cmd), 2);
            put_be({$urandom, $urandom}, 8);
            put_be(offs, 8);
            put_be(64'(len), 4);
            if (cmd == CMD_READ)
                drain(16 + len);
            else if (cmd == CMD_WRITE)
            begin
                repeat (len) put(FUNC_RX, 8'($urandom));
                drain(16);
            end
        end
        if ($urandom_range(0, 1))
        begin
            put_be(64'($urandom), 4);
            put_be(64'($urandom), 2);
            put_be(64'(CMD_DISCONNECT), 2);
            put_be({$urandom, $urandom}, 8);
            put_be({$urandom, $urandom}, 8);
            put_be(64'($urandom), 4);
        end
    endtask

    task automatic write_size(logic [20:0] v);
        disk_size_valid <= 1'b1;
        disk_size <= v;
        @(posedge clk);
        while (!disk_size_ready)
            @(posedge clk);
        disk_size_valid <= 1'b0;
        m_size = v;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver: stall pattern plus one long hold
    initial
    begin
        int hold;
        int held_once;
        hold = 0;
        held_once = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_once && results == 60)
            begin
                held_once = 1;
                hold = 80;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if ((results / 50) % 3 == 2)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        step_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (tx_valid !== e.tv)
                begin
                    $error("tx_valid expected %0d actual %0d", e.tv, tx_valid);
                    errors++;
                end
                if (tx_byte !== e.tb)
                begin
                    $error("tx_byte expected %0h actual %0h", e.tb, tx_byte);
                    errors++;
                end
                if (tx_last !== e.tl)
                begin
                    $error("tx_last expected %0d actual %0d", e.tl, tx_last);
                    errors++;
                end
                if (rx_accepted !== e.acc)
                begin
                    $error("rx_accepted expected %0d actual %0d", e.acc, rx_accepted);
                    errors++;
                end
                if (close_conn !== e.cls)
                begin
                    $error("close_conn expected %0d actual %0d", e.cls, close_conn);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t   rows[$];
        stim_row_t   row;
        int          waited;
        logic [20:0] sizes [2];
        rst_n = 1'b0;
        in_valid <= 1'b0;
        func <= FUNC_TX;
        rx_byte <= 8'd0;
        disk_size_valid <= 1'b0;
        disk_size <= 21'd0;
        restart_link();
        m_size = 21'd1048576;
        for (int i = 0; i < DISK_BYTES; i++)
            m_disk[i] = 8'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        rows.push_back('{FUNC_TX, 8'h00, 1, '0});
        rows.push_back('{FUNC_RX, 8'hff, 1, '0});
        rows.push_back('{2'd3, 8'hff, 1, '0});
        rows.push_back('{FUNC_OPEN, 8'h00, 1, '0});
        rows.push_back('{FUNC_RX, 8'h00, 1, '0});
        rows.push_back('{FUNC_TX, 8'h00, 1, '{1'b1, 8'h4e, 1'b0, 1'b0, 1'b0}});
        for (int i = 1; i < 17; i++)
            rows.push_back('{FUNC_TX, 8'h00, 0, '0});
        rows.push_back('{FUNC_TX, 8'h00, 1, '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0}});
        rows.push_back('{FUNC_RX, 8'hff, 1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0}});
        rows.push_back('{FUNC_TX, 8'hff, 1, '0});
        foreach (rows[i])
        begin
            row = rows[i];
            send(row.f, row.b, row.typed, row.res);
        end
        settle();

        sizes[0] = 21'd1;
        sizes[1] = 21'h1fffff;
        for (int p = 0; p < 2; p++)
        begin
            write_size(sizes[p]);
            run_session();
            settle();
        end

        waited = 0;
        while (expected_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/nbd_pkg.sv
rtl/core/nbd_disk.sv
rtl/core/nbd_ctrl.sv
rtl/core/nbd_server_protocol_engine.sv
sim/testbench.sv
